/* rtl/core/audio_ring_level_corrector_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the audio ring level corrector
// Checks are sampled on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RING_LEVEL_CORRECTOR_UNIT_MACROS_SVH
`define AUDIO_RING_LEVEL_CORRECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ARLC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("level corrector check failed");
// next-cycle implication
`define ARLC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("level corrector check failed");
`else
`define ARLC_ASSERT_IMPLIES(label, ante, cons)
`define ARLC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/arlc_pkg.sv */
// ----------------------------------------------------------------------------
// arlc_pkg
// Types and fixed constants of the audio ring level corrector.
// ----------------------------------------------------------------------------
package arlc_pkg;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_STATS = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TARGET   = 2'd0;
	localparam logic [1:0] CFG_DEADBAND = 2'd1;
	localparam logic [1:0] CFG_LIMIT    = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [10:0] TARGET_RESET   = 11'd768;
	localparam logic [9:0]  DEADBAND_RESET = 10'd96;
	localparam logic [2:0]  LIMIT_RESET    = 3'd3;

	// silence prefilled at reset, before clamping to the ring size
	localparam int PREFILL_LEVEL = 768;

	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 256;

	// input item, first field in the highest bits
	typedef struct packed {
		logic [4:0]         pad;
		logic               burst_start;
		logic [9:0]         frame_length;
		logic signed [15:0] sample;
	} arlc_item_t;

	// result item, first field in the highest bits
	typedef struct packed {
		logic [6:0]  pad;
		logic [31:0] repeated_count;
		logic [31:0] dropped_count;
		logic [31:0] produced_count;
		logic [11:0] current_depth;
		logic [31:0] overrun_count;
		logic [31:0] consumed_count;
		logic [11:0] lowest_depth;
		logic [31:0] underrun_count;
		logic        underran;
		logic [31:0] stereo_word;
	} arlc_result_t;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_LEVEL  = 9'b000000010,
		S_QUOT   = 9'b000000100,
		S_PLACE  = 9'b000001000,
		S_REPEAT = 9'b000010000,
		S_COMMIT = 9'b000100000,
		S_READ   = 9'b001000000,
		S_POPOUT = 9'b010000000,
		S_STATS  = 9'b100000000
	} arlc_state_t;

endpackage

/* rtl/core/audio_ring_level_corrector_unit.sv */
// ----------------------------------------------------------------------------
// audio_ring_level_corrector_unit
// Sample ring with per-frame drop/repeat fill level correction.
// ----------------------------------------------------------------------------
// Push: mid-frame, a place step; a frame start adds a level step and up to
//   correction_limit quotient subtractions; a frame end adds k repeat steps and a commit step.
// Pop: a ring read, then the result is registered once the output register is free, as is a statistics read.
// One transaction in flight at a time: items and register writes are taken only while the sequencer is idle.
// Reset (arst_n low): ready low; pointers, counters, frame state and configuration to defaults.
// The ring store is not swept: the prefilled silence is served by a down-counter.
`include "audio_ring_level_corrector_unit_macros.svh"

module audio_ring_level_corrector_unit
	import arlc_pkg::*;
#(
	parameter int RING_DEPTH = 2048,
	parameter int FRAME_MAX  = 512
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input item stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [15:0] sample, [25:16] frame_length, [26] burst_start, [31:27] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [31:0] stereo_word, [32] underran, [64:33] underrun_count,
	// [76:65] lowest_depth, [108:77] consumed_count, [140:109] overrun_count,
	// [152:141] current_depth, [184:153] produced_count,
	// [216:185] dropped_count, [248:217] repeated_count, [255:249] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// pointers count modulo twice the ring size so that full and empty differ
	localparam int PW   = $clog2(2 * RING_DEPTH);
	localparam int AW   = $clog2(RING_DEPTH);
	localparam int DW   = $clog2(RING_DEPTH + 1);
	localparam int FPW  = $clog2(FRAME_MAX + 1);
	localparam int LNW  = (FPW > 10 ? FPW : 10) + 1;
	localparam int SUMW = FPW + 4;
	localparam int MAXV = (RING_DEPTH > 2048 ? RING_DEPTH : 2048) + 1024;
	localparam int CMPW = $clog2(MAXV + 1);
	localparam int PREFILL = (PREFILL_LEVEL < RING_DEPTH) ? PREFILL_LEVEL : RING_DEPTH;

	localparam logic [PW-1:0]  PTR_LAST   = PW'(2 * RING_DEPTH - 1);
	localparam logic [PW-1:0]  PTR_HALF   = PW'(RING_DEPTH);
	localparam logic [PW:0]    PTR_SPAN   = (PW + 1)'(2 * RING_DEPTH);
	localparam logic [PW-1:0]  PTR_PRE    = PW'(PREFILL);
	localparam logic [DW-1:0]  DEPTH_FULL = DW'(RING_DEPTH);
	localparam logic [DW-1:0]  PRE_COUNT  = DW'(PREFILL);
	localparam logic [LNW-1:0] FRAME_LIM  = LNW'(FRAME_MAX);

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PTR_LAST) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] ptr_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] t;
		if (a >= b) begin
			t = {1'b0, a} - {1'b0, b};
		end else begin
			t = {1'b0, a} + PTR_SPAN - {1'b0, b};
		end
		return t[DW-1:0];
	endfunction

	function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
		logic [PW-1:0] t;
		if (p >= PTR_HALF) begin
			t = p - PTR_HALF;
		end else begin
			t = p;
		end
		return t[AW-1:0];
	endfunction

	// configuration
	logic [10:0] target_q;
	logic [9:0]  deadband_q;
	logic [2:0]  corr_limit_q;

	// sequencer and latched item
	arlc_state_t state_q;
	logic [15:0]    sample_q;
	logic [FPW-1:0] frame_len_q;
	logic           burst_q;

	// ring pointers and frame state
	logic [PW-1:0]   rd_ptr_q, cmt_ptr_q, stg_ptr_q;
	logic [DW-1:0]   pre_left_q;
	logic [FPW-1:0]  frame_pos_q;
	logic [2:0]      frame_corr_q;
	logic [2:0]      rep_cnt_q;
	logic            frame_drops_q, frame_full_q;
	logic [CMPW-1:0] rem_q;

	// pop bookkeeping
	logic from_ram_q, under_q;

	// statistics
	logic [31:0]   underrun_q, consumed_q, overrun_q, produced_q, dropped_q, repeated_q;
	logic          seen_q;
	logic [DW-1:0] least_q;

	// result register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	arlc_item_t   item;
	arlc_result_t result;
	logic [LNW-1:0]  len_ext, len_norm;
	logic [DW-1:0]   cmt_fill, stg_fill, stg_gain;
	logic [9:0]      db_eff;
	logic [CMPW-1:0] dep_x, tgt_x, db_x;
	logic            over_band, under_band;
	logic            stage_full, drop_now, frame_end;
	logic [SUMW-1:0] pos_plus_k, pos_plus_1, len_x;
	logic            out_free, out_load, in_take;
	logic            ram_we, ram_re;
	logic [15:0]     ram_rd_data;

	assign item      = arlc_item_t'(s_tdata);
	assign s_tready  = arst_n && (state_q == S_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign cfg_ready = arst_n && (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = ((state_q == S_POPOUT) || (state_q == S_STATS)) && out_free;

	// normalise frame length: zero reads as one, saturate at FRAME_MAX
	always_comb begin
		len_ext = LNW'(item.frame_length);
		if (len_ext == '0) begin
			len_norm = LNW'(1);
		end else if (len_ext > FRAME_LIM) begin
			len_norm = FRAME_LIM;
		end else begin
			len_norm = len_ext;
		end
	end

	assign cmt_fill = ptr_diff(cmt_ptr_q, rd_ptr_q);
	assign stg_fill = ptr_diff(stg_ptr_q, rd_ptr_q);
	assign stg_gain = ptr_diff(stg_ptr_q, cmt_ptr_q);

	// level comparison operands
	assign db_eff     = (deadband_q == '0) ? 10'd1 : deadband_q;
	assign dep_x      = CMPW'(cmt_fill);
	assign tgt_x      = CMPW'(target_q);
	assign db_x       = CMPW'(db_eff);
	assign over_band  = dep_x > (tgt_x + db_x);
	assign under_band = (dep_x + db_x) < tgt_x;

	assign stage_full = frame_full_q || (stg_fill >= DEPTH_FULL);
	assign pos_plus_k = SUMW'(frame_pos_q) + SUMW'(frame_corr_q);
	assign pos_plus_1 = SUMW'(frame_pos_q) + SUMW'(1);
	assign len_x      = SUMW'(frame_len_q);
	assign drop_now   = frame_drops_q && (pos_plus_k >= len_x);
	assign frame_end  = pos_plus_1 >= len_x;

	// ring store: write on staging, read at the oldest committed slot
	assign ram_we = ((state_q == S_PLACE) && !drop_now && !stage_full) ||
		((state_q == S_REPEAT) && !stage_full);
	assign ram_re = (state_q == S_READ);

	arlc_ram #(
		.WIDTH (16),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ptr_slot(stg_ptr_q)),
		.wr_data (sample_q),
		.rd_en   (ram_re),
		.rd_addr (ptr_slot(rd_ptr_q)),
		.rd_data (ram_rd_data)
	);

	// statistics snapshot for a read-and-clear transaction
	always_comb begin
		result                = '0;
		result.underrun_count = underrun_q;
		result.lowest_depth   = seen_q ? 12'(least_q) : 12'd0;
		result.consumed_count = consumed_q;
		result.overrun_count  = overrun_q;
		result.current_depth  = 12'(cmt_fill);
		result.produced_count = produced_q;
		result.dropped_count  = dropped_q;
		result.repeated_count = repeated_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= TARGET_RESET;
			deadband_q    <= DEADBAND_RESET;
			corr_limit_q  <= LIMIT_RESET;
			state_q       <= S_IDLE;
			rd_ptr_q      <= '0;
			cmt_ptr_q     <= PTR_PRE;
			stg_ptr_q     <= PTR_PRE;
			pre_left_q    <= PRE_COUNT;
			frame_pos_q   <= '0;
			frame_corr_q  <= '0;
			rep_cnt_q     <= '0;
			frame_drops_q <= 1'b0;
			frame_full_q  <= 1'b0;
			rem_q         <= '0;
			from_ram_q    <= 1'b0;
			under_q       <= 1'b0;
			underrun_q    <= '0;
			consumed_q    <= '0;
			overrun_q     <= '0;
			produced_q    <= '0;
			dropped_q     <= '0;
			repeated_q    <= '0;
			seen_q        <= 1'b0;
			least_q       <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TARGET:   target_q     <= cfg_data[10:0];
					CFG_DEADBAND: deadband_q   <= cfg_data[9:0];
					CFG_LIMIT:    corr_limit_q <= cfg_data[2:0];
					default: ;
				endcase
			end

			// hold the result until the consumer takes it, load a new one when free
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						unique case (s_tuser)
							OP_PUSH: begin
								state_q <= (frame_pos_q == '0) ? S_LEVEL : S_PLACE;
							end
							OP_POP:   state_q <= S_READ;
							OP_STATS: state_q <= S_STATS;
							default:  state_q <= S_IDLE;
						endcase
					end
				end

				// frame start: fix direction and seed the quotient
				S_LEVEL: begin
					frame_corr_q  <= '0;
					frame_full_q  <= 1'b0;
					frame_drops_q <= over_band;
					if (over_band) begin
						rem_q   <= dep_x - tgt_x;
						state_q <= S_QUOT;
					end else if (under_band) begin
						rem_q   <= tgt_x - dep_x;
						state_q <= S_QUOT;
					end else begin
						state_q <= S_PLACE;
					end
				end

				// one subtraction of the deadband per cycle, stop at the limit or when the remainder falls below the deadband
				S_QUOT: begin
					if ((frame_corr_q < corr_limit_q) && (rem_q >= db_x)) begin
						rem_q        <= rem_q - db_x;
						frame_corr_q <= frame_corr_q + 3'd1;
					end else begin
						state_q <= S_PLACE;
					end
				end

				S_PLACE: begin
					if (drop_now) begin
						dropped_q <= dropped_q + 32'd1;
					end else if (stage_full) begin
						frame_full_q <= 1'b1;
						overrun_q    <= overrun_q + 32'd1;
					end else begin
						stg_ptr_q <= ptr_next(stg_ptr_q);
					end
					if (frame_end) begin
						if (!frame_drops_q && (frame_corr_q != '0)) begin
							rep_cnt_q <= frame_corr_q;
							state_q   <= S_REPEAT;
						end else begin
							state_q <= S_COMMIT;
						end
					end else begin
						frame_pos_q <= frame_pos_q + 1'b1;
						state_q     <= S_IDLE;
					end
				end

				// repeat the final sample, one ring write per cycle while the ring is not full
				S_REPEAT: begin
					if (stage_full) begin
						frame_full_q <= 1'b1;
						overrun_q    <= overrun_q + 32'd1;
					end else begin
						stg_ptr_q <= ptr_next(stg_ptr_q);
					end
					rep_cnt_q <= rep_cnt_q - 3'd1;
					if (rep_cnt_q == 3'd1) begin
						state_q <= S_COMMIT;
					end
				end

				// publish the staged frame to the consumer
				S_COMMIT: begin
					if (!frame_drops_q) begin
						repeated_q <= repeated_q + 32'(frame_corr_q);
					end
					produced_q    <= produced_q + 32'(stg_gain);
					cmt_ptr_q     <= stg_ptr_q;
					frame_pos_q   <= '0;
					frame_corr_q  <= '0;
					frame_drops_q <= 1'b0;
					frame_full_q  <= 1'b0;
					state_q       <= S_IDLE;
				end

				S_READ: begin
					if (burst_q && (!seen_q || (cmt_fill < least_q))) begin
						seen_q  <= 1'b1;
						least_q <= cmt_fill;
					end
					consumed_q <= consumed_q + 32'd1;
					if (cmt_fill != '0) begin
						rd_ptr_q <= ptr_next(rd_ptr_q);
						under_q  <= 1'b0;
						// prefilled slots were never written and read as silence
						if (pre_left_q != '0) begin
							pre_left_q <= pre_left_q - 1'b1;
							from_ram_q <= 1'b0;
						end else begin
							from_ram_q <= 1'b1;
						end
					end else begin
						underrun_q <= underrun_q + 32'd1;
						under_q    <= 1'b1;
						from_ram_q <= 1'b0;
					end
					state_q <= S_POPOUT;
				end

				// hold until the result register is free
				S_POPOUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end

				S_STATS: begin
					if (out_free) begin
						underrun_q <= '0;
						consumed_q <= '0;
						overrun_q  <= '0;
						produced_q <= '0;
						dropped_q  <= '0;
						repeated_q <= '0;
						seen_q     <= 1'b0;
						state_q    <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q    <= item.sample;
			frame_len_q <= FPW'(len_norm);
			burst_q     <= item.burst_start;
		end
		if ((state_q == S_POPOUT) && out_free) begin
			m_tdata_q <= OUT_TDATA_W'({under_q,
				(from_ram_q ? {ram_rd_data, ram_rd_data} : 32'd0)});
		end else if ((state_q == S_STATS) && out_free) begin
			m_tdata_q <= result;
		end
	end

	// committed and staged data never exceed the ring
	`ARLC_ASSERT_IMPLIES(a_fill_bound, 1'b1, stg_fill <= DEPTH_FULL)
	`ARLC_ASSERT_IMPLIES(a_commit_behind_staging, 1'b1, cmt_fill <= stg_fill)
	// a commit always closes the frame
	`ARLC_ASSERT_NEXT(a_frame_closed, state_q == S_COMMIT, (frame_pos_q == '0) && !frame_full_q)
	// a finished pop waits while the result register is occupied
	`ARLC_ASSERT_NEXT(a_pop_result_held, (state_q == S_POPOUT) && m_tvalid_q && !m_tready, state_q == S_POPOUT)

endmodule

/* rtl/core/arlc_ram.sv */
// ----------------------------------------------------------------------------
// arlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arlc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* tb/audio_ring_level_corrector_unit_tb.sv */
// ----------------------------------------------------------------------------
// audio_ring_level_corrector_unit_tb
// Self-checking bench for the audio ring level corrector. Pushes, pops and
// statistics reads go through the input stream. A built-in predictor of the
// ring, its per-frame drop/repeat correction and its counters works out each
// result. Every result on the output stream is checked field by field
// against the oldest prediction. Traffic drains the ring to underrun and
// fills it to overrun, across several register settings, with random
// idling on both stream sides.
// ----------------------------------------------------------------------------
module audio_ring_level_corrector_unit_tb;
	import arlc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING          = 2048;
	localparam int FRAME_LEN_MAX = 512;
	localparam int SETTLE_CYCLES = 40;    // longest push: level, quotient, repeats, commit
	localparam int STALL_LIMIT   = 2000;  // cycles with no transaction before giving up
	localparam int REPORT_MAX    = 10;

	// operation code that the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	audio_ring_level_corrector_unit #(
		.RING_DEPTH(RING),
		.FRAME_MAX (FRAME_LEN_MAX)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor state: ring, pointers (modulo twice the ring size), frame
	// bookkeeping, statistics and the register copies
	// ------------------------------------------------------------------
	logic [15:0] ring_mem [RING];
	logic [11:0] rd_ptr, commit_ptr, stage_ptr;
	logic [9:0]  frame_pos;
	logic [2:0]  frame_k;
	logic        frame_drop, frame_overflow;
	logic [15:0] last_sample;
	logic        low_seen;
	logic [11:0] low_depth;
	logic [31:0] underrun_tally, consumed_tally, overrun_tally;
	logic [31:0] produced_tally, dropped_tally, repeated_tally;
	logic [10:0] target;
	logic [9:0]  deadband;
	logic [2:0]  corr_limit;

	arlc_result_t expected_results[$];

	// run bookkeeping
	int failures;
	int pushes_sent, pops_sent, stats_sent, reg_writes;
	int underrun_total, overrun_total, dropped_total, repeated_total;
	int gap_pct, stall_pct;
	int frame_plan;
	int idle_cycles;

	function automatic logic [11:0] ring_gap(logic [11:0] a, logic [11:0] b);
		return a - b;
	endfunction

	function automatic void reset_ring_model();
		foreach (ring_mem[i])
			ring_mem[i] = '0;
		rd_ptr         = '0;
		commit_ptr     = (PREFILL_LEVEL > RING) ? 12'(RING) : 12'(PREFILL_LEVEL);
		stage_ptr      = commit_ptr;
		frame_pos      = '0;
		frame_k        = '0;
		frame_drop     = 1'b0;
		frame_overflow = 1'b0;
		last_sample    = '0;
		low_seen       = 1'b0;
		low_depth      = '0;
		underrun_tally = '0;
		consumed_tally = '0;
		overrun_tally  = '0;
		produced_tally = '0;
		dropped_tally  = '0;
		repeated_tally = '0;
		target         = TARGET_RESET;
		deadband       = DEADBAND_RESET;
		corr_limit     = LIMIT_RESET;
	endfunction

	// Place one sample behind the staging pointer; once the ring is full,
	// the rest of the frame is lost as overruns.
	function automatic void stage_one(logic [15:0] s);
		if (frame_overflow || ring_gap(stage_ptr, rd_ptr) >= RING) begin
			frame_overflow = 1'b1;
			overrun_tally++;
			overrun_total++;
		end else begin
			ring_mem[stage_ptr[10:0]] = s;
			stage_ptr++;
		end
	endfunction

	function automatic void ring_push(logic [15:0] s, logic [9:0] len_field);
		int unsigned n, depth, db, k;
		n = len_field;
		if (n == 0)
			n = 1;
		if (n > FRAME_LEN_MAX)
			n = FRAME_LEN_MAX;
		// frame start: fix the correction for the whole frame
		if (frame_pos == 0) begin
			depth      = ring_gap(commit_ptr, rd_ptr);
			db         = (deadband == 0) ? 1 : deadband;
			k          = 0;
			frame_drop = 1'b0;
			if (depth > target + db) begin
				k          = (depth - target) / db;
				frame_drop = 1'b1;
			end else if (depth + db < target) begin
				k = (target - depth) / db;
			end
			if (k > corr_limit)
				k = corr_limit;
			frame_k        = 3'(k);
			frame_overflow = 1'b0;
		end
		last_sample = s;
		if (frame_drop && frame_pos + frame_k >= n) begin
			dropped_tally++;
			dropped_total++;
		end else begin
			stage_one(s);
		end
		// frame end: repeat the last sample if behind, then commit
		if (frame_pos + 1 >= n) begin
			if (!frame_drop && frame_k != 0) begin
				repeat (frame_k)
					stage_one(last_sample);
				repeated_tally += frame_k;
				repeated_total += frame_k;
			end
			produced_tally += ring_gap(stage_ptr, commit_ptr);
			commit_ptr     = stage_ptr;
			frame_pos      = '0;
			frame_k        = '0;
			frame_drop     = 1'b0;
			frame_overflow = 1'b0;
		end else begin
			frame_pos++;
		end
	endfunction

	function automatic arlc_result_t ring_pop(logic burst);
		arlc_result_t r;
		logic [11:0] depth;
		logic [15:0] s;
		r     = '0;
		s     = '0;
		depth = ring_gap(commit_ptr, rd_ptr);
		if (burst && (!low_seen || depth < low_depth)) begin
			low_depth = depth;
			low_seen  = 1'b1;
		end
		if (depth != 0) begin
			s = ring_mem[rd_ptr[10:0]];
			rd_ptr++;
		end else begin
			underrun_tally++;
			underrun_total++;
			r.underran = 1'b1;
		end
		consumed_tally++;
		r.stereo_word = {s, s};
		return r;
	endfunction

	// Report the counters, then clear them
	function automatic arlc_result_t read_stats();
		arlc_result_t r;
		r                = '0;
		r.underrun_count = underrun_tally;
		r.lowest_depth   = low_seen ? low_depth : 12'd0;
		r.consumed_count = consumed_tally;
		r.overrun_count  = overrun_tally;
		r.current_depth  = ring_gap(commit_ptr, rd_ptr);
		r.produced_count = produced_tally;
		r.dropped_count  = dropped_tally;
		r.repeated_count = repeated_tally;
		underrun_tally   = '0;
		consumed_tally   = '0;
		overrun_tally    = '0;
		produced_tally   = '0;
		dropped_tally    = '0;
		repeated_tally   = '0;
		low_seen         = 1'b0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Clock, receiver stalls, result checking and watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold m_tready low in random bursts while stalling is enabled
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= REPORT_MAX)
				$display("%0t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	task automatic check_result(arlc_result_t got);
		arlc_result_t want;
		if (expected_results.size() == 0) begin
			failures++;
			if (failures <= REPORT_MAX)
				$display("%0t result with nothing expected: %h", $realtime, got);
			return;
		end
		want = expected_results.pop_front();
		compare_field("stereo_word",    want.stereo_word,    got.stereo_word);
		compare_field("underran",       want.underran,       got.underran);
		compare_field("underrun_count", want.underrun_count, got.underrun_count);
		compare_field("lowest_depth",   want.lowest_depth,   got.lowest_depth);
		compare_field("consumed_count", want.consumed_count, got.consumed_count);
		compare_field("overrun_count",  want.overrun_count,  got.overrun_count);
		compare_field("current_depth",  want.current_depth,  got.current_depth);
		compare_field("produced_count", want.produced_count, got.produced_count);
		compare_field("dropped_count",  want.dropped_count,  got.dropped_count);
		compare_field("repeated_count", want.repeated_count, got.repeated_count);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(arlc_result_t'(m_tdata));
	end

	// Give up when no transaction moves on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t no transaction for %0d cycles", $realtime, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one item, optionally after a random gap, and predict its result
	// at the edge where the transaction completes. tvalid stays high for
	// the next item unless a gap or a settle lowers it.
	task automatic offer_item(logic [1:0] op, logic [15:0] s, logic [9:0] len, logic burst);
		arlc_item_t item;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item              = '0;
		item.sample       = s;
		item.frame_length = len;
		item.burst_start  = burst;
		s_tvalid <= 1'b1;
		s_tdata  <= item;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		case (op)
			OP_PUSH: begin
				ring_push(s, len);
				pushes_sent++;
			end
			OP_POP: begin
				expected_results.push_back(ring_pop(burst));
				pops_sent++;
			end
			OP_STATS: begin
				expected_results.push_back(read_stats());
				stats_sent++;
			end
			default: ;
		endcase
	endtask

	// Stop offering, let every result arrive, then allow a trailing push
	// to finish its frame work
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TARGET:   target     = value[10:0];
			CFG_DEADBAND: deadband   = value[9:0];
			CFG_LIMIT:    corr_limit = value[2:0];
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(int unsigned t, int unsigned db, int unsigned lim);
		settle();
		write_reg(CFG_TARGET,   CFG_DATA_W'(t));
		write_reg(CFG_DEADBAND, CFG_DATA_W'(db));
		write_reg(CFG_LIMIT,    CFG_DATA_W'(lim));
	endtask

	// Random traffic: pushes come mostly as well-formed frames of a planned
	// length; a few carry a random length, and now and then an unused
	// operation code slips in (not counted).
	task automatic mixed_traffic(int count, int pop_pct, int stats_pct, int frame_max);
		int sent;
		int roll;
		logic [9:0] len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 49) == 0) begin
				offer_item(OP_UNUSED, 16'($urandom), 10'($urandom), 1'($urandom));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < pop_pct) begin
					offer_item(OP_POP, 16'($urandom), 10'($urandom), 1'($urandom));
				end else if (roll < pop_pct + stats_pct) begin
					offer_item(OP_STATS, 16'($urandom), 10'($urandom), 1'($urandom));
				end else begin
					if (frame_pos == 0)
						frame_plan = $urandom_range(1, frame_max);
					len = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'(frame_plan);
					offer_item(OP_PUSH, 16'($urandom), len, 1'($urandom));
				end
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Statistics straight after reset: prefilled depth, no minimum seen
	task automatic test_reset_state();
		offer_item(OP_STATS, 16'h0000, 10'd0, 1'b0);
		offer_item(OP_POP,   16'h0000, 10'd0, 1'b1);
		offer_item(OP_POP,   16'hFFFF, 10'h3FF, 1'b0);
		offer_item(OP_STATS, 16'hFFFF, 10'h3FF, 1'b1);
	endtask

	// Sample extremes, zero and oversized frame length, a shrinking frame
	// and an ignored operation code
	task automatic test_field_extremes();
		offer_item(OP_PUSH,   16'h7FFF, 10'd1,   1'b1);
		offer_item(OP_PUSH,   16'h8000, 10'd0,   1'b0);
		offer_item(OP_PUSH,   16'h0000, 10'h3FF, 1'b0);
		offer_item(OP_PUSH,   16'hFFFF, 10'd2,   1'b1);
		offer_item(OP_UNUSED, 16'hFFFF, 10'h3FF, 1'b1);
	endtask

	// Repeat with the largest target and zero deadband, stay inside a wide
	// band, then drop whole frames when the drop count exceeds their length
	task automatic test_corrections();
		apply_settings(2047, 0, 7);
		offer_item(OP_PUSH, 16'h1234, 10'd1, 1'b0);
		apply_settings(0, 1023, 7);
		offer_item(OP_PUSH, 16'h5A5A, 10'd1, 1'b0);
		apply_settings(0, 1, 7);
		offer_item(OP_PUSH, 16'hA5A5, 10'd2, 1'b0);
		offer_item(OP_PUSH, 16'h0F0F, 10'd2, 1'b0);
		offer_item(OP_STATS, 16'h0000, 10'd0, 1'b0);
	endtask

	// Change every register after the first sample of a frame; the frame
	// keeps the correction it started with
	task automatic test_mid_frame_change();
		apply_settings(0, 1, 2);
		offer_item(OP_PUSH, 16'h1111, 10'd4, 1'b0);
		apply_settings(2047, 1023, 0);
		offer_item(OP_PUSH, 16'h2222, 10'd4, 1'b0);
		offer_item(OP_PUSH, 16'h3333, 10'd4, 1'b0);
		offer_item(OP_PUSH, 16'h4444, 10'd4, 1'b0);
		offer_item(OP_STATS, 16'h0000, 10'd0, 1'b0);
	endtask

	// Drain the ring with pops while pushes are mostly dropped, then keep
	// popping on an empty ring and recover with repeats near a low target
	task automatic test_drain_to_underrun();
		int rounds;
		rounds = 0;
		apply_settings(0, $urandom_range(1, 8), $urandom_range(4, 7));
		gap_pct   = 20;
		stall_pct = 20;
		while (ring_gap(commit_ptr, rd_ptr) != 0 && rounds < 25) begin
			// alternate stretches with and without idling
			gap_pct   = (rounds % 3 == 2) ? 0 : 20;
			stall_pct = (rounds % 3 == 1) ? 0 : 25;
			mixed_traffic(50, 96, 2, 3);
			rounds++;
		end
		mixed_traffic(20, 80, 5, 3);
		apply_settings($urandom_range(16, 128), $urandom_range(1, 16), $urandom_range(1, 7));
		mixed_traffic(30, 55, 5, 4);
	endtask

	// Fill the ring with single-sample frames and full repeats until it
	// overflows, then run on at the top
	task automatic test_fill_to_overrun();
		int rounds;
		rounds = 0;
		apply_settings(2047, $urandom_range(1, 4), 7);
		gap_pct   = 15;
		stall_pct = 30;
		while (overrun_total == 0 && rounds < 15) begin
			mixed_traffic(40, 5, 3, 1);
			rounds++;
		end
		mixed_traffic(20, 10, 5, 2);
	endtask

	// Balanced traffic with no idling under a random setting; a full ring
	// makes drops likely
	task automatic test_settled_traffic();
		apply_settings($urandom_range(0, 2047), $urandom_range(1, 1023), $urandom_range(0, 7));
		gap_pct   = 0;
		stall_pct = 0;
		mixed_traffic(50, 45, 5, 6);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_PUSH;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TARGET;
		cfg_data  <= '0;
		failures       = 0;
		pushes_sent    = 0;
		pops_sent      = 0;
		stats_sent     = 0;
		reg_writes     = 0;
		underrun_total = 0;
		overrun_total  = 0;
		dropped_total  = 0;
		repeated_total = 0;
		gap_pct        = 0;
		stall_pct      = 0;
		frame_plan     = 1;
		reset_ring_model();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed checks run with light idling on both sides
		gap_pct   = 30;
		stall_pct = 30;
		test_reset_state();
		test_field_extremes();
		test_corrections();
		test_mid_frame_change();

		test_drain_to_underrun();
		test_fill_to_overrun();
		test_settled_traffic();

		settle();
		$display("Covered %0d pushes, %0d pops, %0d statistics reads, %0d register writes.",
			pushes_sent, pops_sent, stats_sent, reg_writes);
		$display("Saw %0d underruns, %0d overruns, %0d dropped and %0d repeated samples.",
			underrun_total, overrun_total, dropped_total, repeated_total);
		if (failures == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", failures,
				expected_results.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
